// ===== sv/epfp_pkg.sv =====
package epfp_pkg;

    localparam logic [1:0] REQ_POLL    = 2'd0;
    localparam logic [1:0] REQ_BYTE    = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    localparam logic [7:0] SOF_CHAR     = 8'h23;
    localparam logic [7:0] DIGIT_ZERO   = 8'h30;
    localparam logic [3:0] MAX_SLAVE    = 4'd9;
    localparam logic [4:0] BODY_LEN     = 5'd21;
    localparam logic [7:0] SEARCH_RESET = 8'd50;

    localparam logic [4:0] F0_FIRST = 5'd5;
    localparam logic [4:0] F0_LAST  = 5'd8;
    localparam logic [4:0] F1_FIRST = 5'd11;
    localparam logic [4:0] F1_LAST  = 5'd14;
    localparam logic [4:0] F2_FIRST = 5'd17;
    localparam logic [4:0] F2_LAST  = 5'd20;

    typedef enum logic [1:0] {
        KIND_TX   = 2'd0,
        KIND_MEAS = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_BAD_SLAVE = 2'd1,
        ERR_NO_RESP   = 2'd2,
        ERR_CORRUPT   = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SEARCH = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        OP_POLL     = 2'd0,
        OP_BAD_POLL = 2'd1,
        OP_BYTE     = 2'd2,
        OP_TIMEOUT  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] slave_number;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        kind_t             result_kind;
        logic [7:0]        tx_byte;
        logic [3:0]        meas_slave;
        logic [15:0]       status_word;
        logic signed [15:0] angle_raw;
        logic signed [15:0] speed_raw;
        err_t              error_code;
        logic              last_result;
    } out_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] slave;
        logic       is_sof;
        logic       hex_ok;
        logic [3:0] nib;
    } cmd_t;

endpackage

// ===== sv/epfp_front.sv =====
module epfp_front
    import epfp_pkg::*;
(
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_request,
    input  logic q_ready,
    output logic push,
    output cmd_t cmd
);

    logic [7:0] b;

    assign b       = s_request.rx_byte;
    assign s_ready = q_ready;
    // request type three is taken and dropped
    assign push    = s_valid && q_ready && (s_request.req_type != REQ_UNUSED);

    always_comb begin
        cmd        = '0;
        cmd.slave  = s_request.slave_number;
        cmd.is_sof = (b == SOF_CHAR);
        unique case (s_request.req_type)
            REQ_POLL: begin
                cmd.op = (s_request.slave_number > MAX_SLAVE) ? OP_BAD_POLL : OP_POLL;
            end
            REQ_BYTE:    cmd.op = OP_BYTE;
            REQ_TIMEOUT: cmd.op = OP_TIMEOUT;
            default:     cmd.op = OP_TIMEOUT;
        endcase
        priority if (b >= 8'h30 && b <= 8'h39) begin
            cmd.hex_ok = 1'b1;
            cmd.nib    = b[3:0];
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            cmd.hex_ok = 1'b1;
            cmd.nib    = b[3:0] + 4'd9;
        end else begin
            cmd.hex_ok = 1'b0;
            cmd.nib    = 4'd0;
        end
    end

endmodule

// ===== sv/epfp_queue.sv =====
module epfp_queue
    import epfp_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic q_ready,
    input  logic pop,
    output logic head_valid,
    output cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_ready    = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/epfp_back.sv =====
module epfp_back
    import epfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       head_valid,
    input  cmd_t       head,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_result
);

    logic [7:0]  limit_reg;
    phase_t      phase_reg, phase_next;
    logic [7:0]  search_reg, search_next;
    logic [4:0]  index_reg, index_next;
    logic [3:0]  slave_reg, slave_next;
    logic [15:0] acc_reg [3];
    logic [15:0] acc_next [3];
    logic        bad_reg, bad_next;
    logic        beat_reg, beat_next;
    logic        valid_reg, valid_next;
    out_t        out_reg, out_next;

    logic        can_load;
    logic        emit;
    out_t        res;
    logic [7:0]  search_inc;
    logic [4:0]  index_inc;
    logic [1:0]  fsel;
    logic        in_field;

    assign can_load   = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign m_result   = out_reg;
    assign search_inc = (search_reg != 8'hFF) ? search_reg + 8'd1 : search_reg;
    assign index_inc  = index_reg + 5'd1;

    always_comb begin
        in_field = 1'b1;
        fsel     = 2'd0;
        priority if (index_reg >= F0_FIRST && index_reg <= F0_LAST) begin
            fsel = 2'd0;
        end else if (index_reg >= F1_FIRST && index_reg <= F1_LAST) begin
            fsel = 2'd1;
        end else if (index_reg >= F2_FIRST && index_reg <= F2_LAST) begin
            fsel = 2'd2;
        end else begin
            in_field = 1'b0;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        search_next = search_reg;
        index_next  = index_reg;
        slave_next  = slave_reg;
        acc_next    = acc_reg;
        bad_next    = bad_reg;
        beat_next   = beat_reg;
        emit        = 1'b0;
        res         = '0;
        res.result_kind = KIND_ERR;
        res.error_code  = ERR_NONE;
        res.last_result = 1'b1;

        unique case (head.op)
            OP_POLL: begin
                emit = 1'b1;
                res.result_kind = KIND_TX;
                if (!beat_reg) begin
                    res.tx_byte     = SOF_CHAR;
                    res.last_result = 1'b0;
                end else begin
                    res.tx_byte = DIGIT_ZERO + {4'd0, head.slave};
                end
            end
            OP_BAD_POLL: begin
                emit = 1'b1;
                res.error_code = ERR_BAD_SLAVE;
            end
            OP_TIMEOUT: begin
                emit = (phase_reg != PH_IDLE);
                res.error_code = (phase_reg == PH_SEARCH) ? ERR_NO_RESP : ERR_CORRUPT;
            end
            OP_BYTE: begin
                if (phase_reg == PH_SEARCH && !head.is_sof) begin
                    emit = (search_inc >= limit_reg);
                    res.error_code = ERR_CORRUPT;
                end else if (phase_reg == PH_BODY && index_inc == BODY_LEN) begin
                    emit = 1'b1;
                    if (bad_reg || (in_field && !head.hex_ok)) begin
                        res.error_code = ERR_CORRUPT;
                    end else begin
                        res.result_kind = KIND_MEAS;
                        res.meas_slave  = slave_reg;
                        res.status_word = acc_reg[0];
                        res.angle_raw   = acc_reg[1];
                        res.speed_raw   = {acc_reg[2][11:0], head.nib};
                    end
                end
            end
            default: emit = 1'b0;
        endcase

        pop = head_valid && (!emit || can_load) && !(head.op == OP_POLL && !beat_reg);

        if (head_valid && emit && can_load && head.op == OP_POLL) begin
            beat_next = !beat_reg;
        end

        if (pop) begin
            unique case (head.op)
                OP_POLL: begin
                    phase_next  = PH_SEARCH;
                    search_next = 8'd0;
                    index_next  = 5'd0;
                    slave_next  = head.slave;
                    acc_next    = '{16'd0, 16'd0, 16'd0};
                    bad_next    = 1'b0;
                end
                OP_BAD_POLL: phase_next = PH_IDLE;
                OP_TIMEOUT:  phase_next = PH_IDLE;
                OP_BYTE: begin
                    if (phase_reg == PH_SEARCH) begin
                        if (head.is_sof) begin
                            phase_next = PH_BODY;
                            index_next = 5'd0;
                        end else begin
                            search_next = search_inc;
                            if (emit) begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end else if (phase_reg == PH_BODY) begin
                        index_next = index_inc;
                        if (in_field) begin
                            if (head.hex_ok) begin
                                acc_next[fsel] = {acc_reg[fsel][11:0], head.nib};
                            end else begin
                                bad_next = 1'b1;
                            end
                        end
                        if (emit) begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end

        valid_next = valid_reg;
        out_next   = out_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (head_valid && emit && can_load) begin
            valid_next = 1'b1;
            out_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg  <= SEARCH_RESET;
            phase_reg  <= PH_IDLE;
            search_reg <= '0;
            index_reg  <= '0;
            slave_reg  <= '0;
            acc_reg    <= '{16'd0, 16'd0, 16'd0};
            bad_reg    <= 1'b0;
            beat_reg   <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            phase_reg  <= phase_next;
            search_reg <= search_next;
            index_reg  <= index_next;
            slave_reg  <= slave_next;
            acc_reg    <= acc_next;
            bad_reg    <= bad_next;
            beat_reg   <= beat_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

// ===== sv/encoder_poll_frame_parser.sv =====
// Path: a request taken is written into the queue buffer, read by the parser at its head,
// and its result is registered in the output register; a poll gives its second transmit
// byte from the same register once the first is taken. Throughput: one request per cycle
// while the queue has room; a good poll gives two results in turn through the single
// output register. Requests queue in a DEPTH-entry buffer ahead of the parser.
// Reset (aresetn low, synchronous): queue emptied, parser idle, no result pending, search limit back to 50.
module encoder_poll_frame_parser
    import epfp_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_t        s_request,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_result,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    logic q_ready;
    logic push;
    cmd_t cmd;
    logic pop;
    logic head_valid;
    cmd_t head;

    epfp_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_request (s_request),
        .q_ready   (q_ready),
        .push      (push),
        .cmd       (cmd)
    );

    epfp_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (cmd),
        .q_ready    (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    epfp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

endmodule

// ===== bench/epfp_checker.sv =====
module epfp_checker
    import epfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  in_t        s_request,
    input  logic       m_valid,
    input  logic       m_ready,
    input  out_t       m_result,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    output int         mismatches,
    output int         results_due
);

    out_t        due_q[$];
    phase_t      link_phase;
    logic [7:0]  search_limit;
    logic [7:0]  search_cnt;
    logic [4:0]  body_idx;
    logic [3:0]  polled;
    logic [15:0] field_acc [3];
    logic        digit_bad;

    task automatic push_error(input err_t code);
        out_t r;
        r = '0;
        r.result_kind = KIND_ERR;
        r.error_code  = code;
        r.last_result = 1'b1;
        due_q.push_back(r);
    endtask

    task automatic parse_request(input in_t rq);
        out_t       r;
        logic [4:0] rel;
        logic [7:0] b;
        logic [3:0] nib;
        logic       nib_ok;
        case (rq.req_type)
            REQ_POLL: begin
                if (rq.slave_number > MAX_SLAVE) begin
                    link_phase = PH_IDLE;
                    push_error(ERR_BAD_SLAVE);
                end else begin
                    link_phase = PH_SEARCH;
                    search_cnt = '0;
                    body_idx   = '0;
                    polled     = rq.slave_number;
                    for (int i = 0; i < 3; i++) field_acc[i] = '0;
                    digit_bad  = 1'b0;
                    r = '0;
                    r.result_kind = KIND_TX;
                    r.tx_byte     = SOF_CHAR;
                    due_q.push_back(r);
                    r.tx_byte     = DIGIT_ZERO + {4'd0, rq.slave_number};
                    r.last_result = 1'b1;
                    due_q.push_back(r);
                end
            end
            REQ_TIMEOUT: begin
                if (link_phase == PH_SEARCH) push_error(ERR_NO_RESP);
                else if (link_phase == PH_BODY) push_error(ERR_CORRUPT);
                link_phase = PH_IDLE;
            end
            REQ_BYTE: begin
                b = rq.rx_byte;
                if (link_phase == PH_SEARCH) begin
                    if (b == SOF_CHAR) begin
                        link_phase = PH_BODY;
                        body_idx   = '0;
                    end else begin
                        if (search_cnt != 8'hFF) search_cnt++;
                        if (search_cnt >= search_limit) begin
                            link_phase = PH_IDLE;
                            push_error(ERR_CORRUPT);
                        end
                    end
                end else if (link_phase == PH_BODY) begin
                    if (body_idx >= F0_FIRST) begin
                        rel = body_idx - F0_FIRST;
                        if ((rel % 6) < 4 && (rel / 6) < 3) begin
                            nib_ok = 1'b1;
                            if (b >= "0" && b <= "9") nib = 4'(b - "0");
                            else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
                            else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
                            else nib_ok = 1'b0;
                            if (nib_ok) field_acc[rel / 6] = {field_acc[rel / 6][11:0], nib};
                            else digit_bad = 1'b1;
                        end
                    end
                    body_idx++;
                    if (body_idx >= BODY_LEN) begin
                        link_phase = PH_IDLE;
                        if (digit_bad) begin
                            push_error(ERR_CORRUPT);
                        end else begin
                            r = '0;
                            r.result_kind = KIND_MEAS;
                            r.meas_slave  = polled;
                            r.status_word = field_acc[0];
                            r.angle_raw   = field_acc[1];
                            r.speed_raw   = field_acc[2];
                            r.last_result = 1'b1;
                            due_q.push_back(r);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            link_phase   = PH_IDLE;
            search_limit = SEARCH_RESET;
            search_cnt   = '0;
            body_idx     = '0;
            polled       = '0;
            for (int i = 0; i < 3; i++) field_acc[i] = '0;
            digit_bad    = 1'b0;
            due_q.delete();
        end else begin
            if (cfg_we) search_limit = cfg_wdata;
            if (s_valid && s_ready) parse_request(s_request);
            if (m_valid && m_ready) begin
                if (due_q.size() == 0) begin
                    $error("result_kind: expected none, got %0h", m_result.result_kind);
                    mismatches++;
                end else begin
                    want = due_q.pop_front();
                    check_field("result_kind", want.result_kind, m_result.result_kind);
                    check_field("tx_byte", want.tx_byte, m_result.tx_byte);
                    check_field("meas_slave", want.meas_slave, m_result.meas_slave);
                    check_field("status_word", want.status_word, m_result.status_word);
                    check_field("angle_raw", want.angle_raw, m_result.angle_raw);
                    check_field("speed_raw", want.speed_raw, m_result.speed_raw);
                    check_field("error_code", want.error_code, m_result.error_code);
                    check_field("last_result", want.last_result, m_result.last_result);
                end
            end
        end
        results_due = due_q.size();
    end

endmodule

// ===== bench/tb_encoder_poll_frame_parser.sv =====
module tb_encoder_poll_frame_parser;
    import epfp_pkg::*;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       m_ready   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = '0;
    in_t        s_request = '0;
    logic       s_ready;
    logic       m_valid;
    out_t       m_result;
    int         mismatches;
    int         results_due;

    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int         hold_asked    = 0;
    int         hold_done     = 0;
    int         items_sent    = 0;
    logic [7:0] limit_now     = SEARCH_RESET;

    encoder_poll_frame_parser uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_request (s_request),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    epfp_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_request   (s_request),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_asked != hold_done) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_done++;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_req(input in_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_request <= r;
        do @(posedge aclk); while (!s_ready);
        if (r.req_type != REQ_UNUSED) items_sent++;
    endtask

    task automatic poll(input logic [3:0] slave);
        send_req(in_t'{req_type: REQ_POLL, slave_number: slave, rx_byte: 8'($urandom)});
    endtask

    task automatic rx(input logic [7:0] b);
        send_req(in_t'{req_type: REQ_BYTE, slave_number: 4'($urandom), rx_byte: b});
    endtask

    task automatic timeout_req();
        send_req(in_t'{req_type: REQ_TIMEOUT, slave_number: 4'($urandom),
                       rx_byte: 8'($urandom)});
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return DIGIT_ZERO + {4'd0, nib};
        return ($urandom_range(1) ? "A" : "a") + {4'd0, nib} - 8'd10;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] b;
        do b = 8'($urandom);
        while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f"));
        return b;
    endfunction

    function automatic logic [7:0] rand_noise();
        logic [7:0] b;
        do b = 8'($urandom); while (b == SOF_CHAR);
        return b;
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // digit index 0..11 across the three hex fields, -1 elsewhere
    function automatic int digit_slot(input int i);
        if (i >= F0_FIRST && i <= F0_LAST) return i - F0_FIRST;
        if (i >= F1_FIRST && i <= F1_LAST) return 4 + i - F1_FIRST;
        if (i >= F2_FIRST && i <= F2_LAST) return 8 + i - F2_FIRST;
        return -1;
    endfunction

    task automatic send_body(input logic [47:0] fields, input int bad_slot,
                             input int stop_at);
        int         d;
        logic [7:0] b;
        for (int i = 0; i < BODY_LEN; i++) begin
            if (i == stop_at) begin
                timeout_req();
                return;
            end
            d = digit_slot(i);
            if (d < 0) b = ($urandom_range(7) == 0) ? SOF_CHAR : 8'($urandom);
            else if (d == bad_slot) b = rand_non_hex();
            else b = hex_char(fields[47 - 4 * d -: 4]);
            rx(b);
        end
    endtask

    task automatic exchange();
        int          pick;
        int          lim;
        int          n;
        int          bad;
        logic [3:0]  slave;
        logic [13:0] bits;
        pick  = $urandom_range(99);
        lim   = (limit_now == 0) ? 1 : limit_now;
        slave = 4'($urandom_range(9));
        n     = $urandom_range(0, (lim > 5) ? 4 : lim - 1);
        if (pick < 60) begin
            bad = ($urandom_range(9) == 0) ? $urandom_range(11) : -1;
            poll(slave);
            repeat (n) rx(rand_noise());
            rx(SOF_CHAR);
            send_body({rand_word(), rand_word(), rand_word()}, bad, -1);
        end else if (pick < 68) begin
            poll(slave);
            repeat (n) rx(rand_noise());
            rx(SOF_CHAR);
            send_body({rand_word(), rand_word(), rand_word()}, -1, $urandom_range(20));
        end else if (pick < 74) begin
            poll(slave);
            repeat (n) rx(rand_noise());
            timeout_req();
        end else if (pick < 78) begin
            poll(slave);
            if (lim <= 60 || $urandom_range(19) == 0) repeat (lim) rx(rand_noise());
        end else if (pick < 84) begin
            // abandoned mid-way; the next poll restarts
            poll(slave);
            if ($urandom_range(1)) rx(SOF_CHAR);
            repeat ($urandom_range(6)) rx(8'($urandom));
        end else if (pick < 88) begin
            poll(4'($urandom_range(10, 15)));
        end else begin
            repeat ($urandom_range(1, 3)) begin
                bits = 14'($urandom);
                send_req(bits);
            end
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        limit_now = v;
    endtask

    task automatic run_phase(input logic [7:0] lim, input int idle, input int stall,
                             input int n_items, input bit hold);
        int target;
        wait_idle();
        write_limit(lim);
        send_idle_pct = idle;
        stall_pct     = stall;
        if (hold) hold_asked++;
        target = items_sent + n_items / 2;
        while (items_sent < target) exchange();
        wait_idle();
        target = items_sent + n_items / 2;
        while (items_sent < target) exchange();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle noise, bad slaves, timeouts in each phase, restart while busy
        rx(SOF_CHAR);
        timeout_req();
        send_req(in_t'{req_type: REQ_UNUSED, slave_number: 4'hF, rx_byte: 8'hFF});
        poll(4'd15);
        poll(4'd10);
        poll(4'd9);
        timeout_req();
        poll(4'd0);
        poll(4'd5);
        rx(8'hFF);
        rx(8'h00);
        rx(SOF_CHAR);
        rx(SOF_CHAR);
        rx(8'h00);
        timeout_req();
        poll(4'd3);
        rx(SOF_CHAR);
        poll(4'd7);
        timeout_req();
        while (items_sent < 100) exchange();

        run_phase(8'd255, 0, 0, 100, 1'b0);
        run_phase(8'd1, 67, 0, 120, 1'b0);
        run_phase(8'd0, 0, 67, 120, 1'b1);
        run_phase(8'($urandom_range(2, 30)), 37, 37, 120, 1'b0);
        run_phase(SEARCH_RESET, 67, 67, 100, 1'b1);

        wait_idle();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/epfp_pkg.sv
sv/epfp_front.sv
sv/epfp_queue.sv
sv/epfp_back.sv
sv/encoder_poll_frame_parser.sv
bench/epfp_checker.sv
bench/tb_encoder_poll_frame_parser.sv
